// ----- src/dwfs_pkg.sv -----
// shared constants and helpers for the damped 2d wave fdtd step unit
`default_nettype none
package dwfs_pkg;
   localparam int GRID_X = 64;
   localparam int GRID_Y = 64;
   localparam int CELLS  = GRID_X * GRID_Y;
   localparam int XW     = $clog2(GRID_X);
   localparam int YW     = $clog2(GRID_Y);
   localparam int AW     = XW + YW;
   localparam int TAPS   = 2 * GRID_Y + 1;

   // register indexes on the csr port
   localparam logic [2:0] REG_COEF_CENTER   = 3'd0;
   localparam logic [2:0] REG_COEF_PREV     = 3'd1;
   localparam logic [2:0] REG_COEF_NEIGHBOR = 3'd2;
   localparam logic [2:0] REG_INJ_W_LOW     = 3'd3;
   localparam logic [2:0] REG_INJ_W_HIGH    = 3'd4;
   localparam logic [2:0] REG_INJ_POS       = 3'd5;
   localparam logic [2:0] REG_PICK_POS      = 3'd6;
   localparam logic [2:0] REG_PICK_W        = 3'd7;

   localparam logic [AW-1:0] POS_RESET = AW'(2145);

   typedef logic [AW-1:0] addr_type;

   // saturate to signed 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) r = 32'sh7fffffff;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction
endpackage
`default_nettype wire

// ----- src/damped_wave2d_fdtd_step_unit.sv -----
// top level: damped 2d wave fdtd step with injection and bilinear pickup
//
// channel  direction  handshake            payload
// req      in         req_tvalid/tready    req_tdata[23:0] excitation
// rsp      out        rsp_tvalid/tready    rsp_tdata[31:0] pickup_sample
// csr      in         apb write/read       64-bit registers at 8*index
//
// a word passes idle, setup, scan, drain and pickup (the four corner reads, then the sum)
// before the next word is taken; the scan reads one grid address per cycle on the
// single read port of the current-grid ram.
// after reset a clearing pass over all 4096 cells zeroes both rams; req_tready
// stays low meanwhile, csr writes are taken as ever.
// a new word is taken while a result waits on rsp; the pickup end holds until rsp is free.
`default_nettype none
module damped_wave2d_fdtd_step_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [23:0] excitation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,   // [31:0] pickup_sample
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [5:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic      [63:0] csr_prdata,
   output logic             csr_pready
);
   localparam int AW = dwfs_pkg::AW;
   localparam int XW = dwfs_pkg::XW;
   localparam int YW = dwfs_pkg::YW;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_PREP, ST_PREP2, ST_SCAN, ST_DRAIN, ST_PICK, ST_PICKW
   } state_type;

   state_type state_ff;
   dwfs_pkg::addr_type cnt_ff;
   logic bank_ff;

   // configuration registers
   logic signed [31:0] coef_c_ff, coef_p_ff, coef_n_ff;
   logic [63:0] inj_w_lo_ff, inj_w_hi_ff, pick_w_ff;
   dwfs_pkg::addr_type inj_pos_ff, pick_pos_ff;

   logic signed [23:0] exc_ff;
   logic signed [55:0] injp_ff [0:3];
   logic signed [16:0] inj_ff [0:3];
   dwfs_pkg::addr_type ipos_ff, ppos_ff;

   // ram interface
   logic [31:0] rd0, rd1;
   logic signed [31:0] rd_now, rd_bef;
   dwfs_pkg::addr_type now_raddr, bef_raddr, waddr;
   logic we0, we1, wr_pt;
   logic [31:0] wdata;

   // scan pipeline
   logic sh1_ff, v1_ff, v2_ff, va_ff, vb_ff, vc_ff;
   dwfs_pkg::addr_type p1_ff, p2_ff, pa_ff, pb_ff, pc_ff;
   logic signed [31:0] tap_ff [0:dwfs_pkg::TAPS-1];
   logic signed [31:0] bef2_ff, ua_ff, ba_ff;
   logic signed [33:0] nsum_a_ff;
   logic signed [63:0] mc_b_ff, mp_b_ff;
   logic signed [49:0] mh_b_ff;
   logic signed [48:0] ml_b_ff;
   logic signed [33:0] tc_c_ff, tp_c_ff;
   logic signed [35:0] tn_c_ff;
   logic signed [16:0] is_c_ff;
   logic pipe_busy;

   // pickup pipeline
   logic pk1_v_ff, pk2_v_ff;
   logic [1:0] pk1_k_ff;
   logic signed [48:0] pm_ff;
   logic signed [50:0] pacc_ff;

   logic rsp_v_ff;
   logic [31:0] rsp_d_ff;

   // combinational helpers
   logic csr_wr;
   logic [2:0] csr_idx;
   logic signed [33:0] nsum_in;
   logic signed [63:0] rc_sum, rp_sum;
   logic signed [65:0] rn_sum;
   logic signed [37:0] acc;
   logic signed [16:0] is_in;
   logic signed [50:0] pround;
   dwfs_pkg::addr_type pick_addr;
   logic [15:0] pw_sel;
   logic signed [31:0] w_inj [0:3];
   logic pick_done;

   function automatic logic [XW-1:0] clampx(input logic [XW-1:0] v, input int lo, input int hi);
      logic [XW-1:0] r;
      if (v < XW'(lo)) r = XW'(lo);
      else if (v > XW'(hi)) r = XW'(hi);
      else r = v;
      return r;
   endfunction

   function automatic logic [YW-1:0] clampy(input logic [YW-1:0] v, input int lo, input int hi);
      logic [YW-1:0] r;
      if (v < YW'(lo)) r = YW'(lo);
      else if (v > YW'(hi)) r = YW'(hi);
      else r = v;
      return r;
   endfunction

   function automatic logic interior(input dwfs_pkg::addr_type p);
      logic [XW-1:0] x;
      logic [YW-1:0] y;
      x = p[AW-1:YW];
      y = p[YW-1:0];
      return (x >= XW'(1)) && (x <= XW'(dwfs_pkg::GRID_X - 2)) &&
             (y >= YW'(1)) && (y <= YW'(dwfs_pkg::GRID_Y - 2));
   endfunction

   // csr decode
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[5:3];

   always_comb begin
      case (csr_idx)
         dwfs_pkg::REG_COEF_CENTER:   csr_prdata = {{32{coef_c_ff[31]}}, coef_c_ff};
         dwfs_pkg::REG_COEF_PREV:     csr_prdata = {{32{coef_p_ff[31]}}, coef_p_ff};
         dwfs_pkg::REG_COEF_NEIGHBOR: csr_prdata = {{32{coef_n_ff[31]}}, coef_n_ff};
         dwfs_pkg::REG_INJ_W_LOW:     csr_prdata = inj_w_lo_ff;
         dwfs_pkg::REG_INJ_W_HIGH:    csr_prdata = inj_w_hi_ff;
         dwfs_pkg::REG_INJ_POS:       csr_prdata = 64'(inj_pos_ff);
         dwfs_pkg::REG_PICK_POS:      csr_prdata = 64'(pick_pos_ff);
         dwfs_pkg::REG_PICK_W:        csr_prdata = pick_w_ff;
         default:                     csr_prdata = 64'd0;
      endcase
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_c_ff   <= '0;
         coef_p_ff   <= '0;
         coef_n_ff   <= '0;
         inj_w_lo_ff <= '0;
         inj_w_hi_ff <= '0;
         pick_w_ff   <= '0;
         inj_pos_ff  <= dwfs_pkg::POS_RESET;
         pick_pos_ff <= dwfs_pkg::POS_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            dwfs_pkg::REG_COEF_CENTER:   coef_c_ff   <= csr_pwdata[31:0];
            dwfs_pkg::REG_COEF_PREV:     coef_p_ff   <= csr_pwdata[31:0];
            dwfs_pkg::REG_COEF_NEIGHBOR: coef_n_ff   <= csr_pwdata[31:0];
            dwfs_pkg::REG_INJ_W_LOW:     inj_w_lo_ff <= csr_pwdata;
            dwfs_pkg::REG_INJ_W_HIGH:    inj_w_hi_ff <= csr_pwdata;
            dwfs_pkg::REG_INJ_POS:       inj_pos_ff  <= csr_pwdata[AW-1:0];
            dwfs_pkg::REG_PICK_POS:      pick_pos_ff <= csr_pwdata[AW-1:0];
            dwfs_pkg::REG_PICK_W:        pick_w_ff   <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // rams: bank_ff low means ram0 holds the current grid
   assign rd_now = bank_ff ? rd1 : rd0;
   assign rd_bef = bank_ff ? rd0 : rd1;
   assign bef_raddr = cnt_ff - AW'(dwfs_pkg::GRID_Y);
   assign now_raddr = (state_ff == ST_PICK) ? pick_addr : cnt_ff;
   assign wr_pt = vc_ff && interior(pc_ff);
   assign we0 = (state_ff == ST_CLEAR) | (wr_pt & bank_ff);
   assign we1 = (state_ff == ST_CLEAR) | (wr_pt & ~bank_ff);
   assign waddr = (state_ff == ST_CLEAR) ? cnt_ff : pc_ff;
   assign wdata = (state_ff == ST_CLEAR) ? 32'd0 : dwfs_pkg::sat32(64'(acc));

   dwfs_ram #(.DEPTH(dwfs_pkg::CELLS), .WIDTH(32)) u_ram0 (
      .clock(clock), .we(we0), .waddr(waddr), .wdata(wdata),
      .raddr(bank_ff ? bef_raddr : now_raddr), .rdata(rd0)
   );

   dwfs_ram #(.DEPTH(dwfs_pkg::CELLS), .WIDTH(32)) u_ram1 (
      .clock(clock), .we(we1), .waddr(waddr), .wdata(wdata),
      .raddr(bank_ff ? now_raddr : bef_raddr), .rdata(rd1)
   );

   // point arithmetic
   assign nsum_in = 34'(tap_ff[0]) + 34'(tap_ff[dwfs_pkg::GRID_Y - 1]) +
                    34'(tap_ff[dwfs_pkg::GRID_Y + 1]) + 34'(tap_ff[2 * dwfs_pkg::GRID_Y]);
   assign rc_sum = mc_b_ff + 64'sd536870912;
   assign rp_sum = mp_b_ff + 64'sd536870912;
   assign rn_sum = {mh_b_ff, 16'd0} + 66'(ml_b_ff) + 66'sd536870912;
   assign acc = 38'(tc_c_ff) + 38'(tp_c_ff) + 38'(tn_c_ff) + 38'(is_c_ff);

   // injection corner select
   always_comb begin
      if (pb_ff == ipos_ff) is_in = inj_ff[0];
      else if (pb_ff == ipos_ff + AW'(1)) is_in = inj_ff[1];
      else if (pb_ff == ipos_ff + AW'(dwfs_pkg::GRID_Y)) is_in = inj_ff[2];
      else if (pb_ff == ipos_ff + AW'(dwfs_pkg::GRID_Y + 1)) is_in = inj_ff[3];
      else is_in = 17'sd0;
   end

   assign w_inj[0] = inj_w_lo_ff[31:0];
   assign w_inj[1] = inj_w_lo_ff[63:32];
   assign w_inj[2] = inj_w_hi_ff[31:0];
   assign w_inj[3] = inj_w_hi_ff[63:32];

   // pickup address and weight
   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    pick_addr = ppos_ff;
         2'd1:    pick_addr = ppos_ff + AW'(1);
         2'd2:    pick_addr = ppos_ff + AW'(dwfs_pkg::GRID_Y);
         default: pick_addr = ppos_ff + AW'(dwfs_pkg::GRID_Y + 1);
      endcase
      case (pk1_k_ff)
         2'd0:    pw_sel = pick_w_ff[15:0];
         2'd1:    pw_sel = pick_w_ff[31:16];
         2'd2:    pw_sel = pick_w_ff[47:32];
         default: pw_sel = pick_w_ff[63:48];
      endcase
   end

   assign pround = pacc_ff + 51'sd16384;
   assign pipe_busy = sh1_ff | v1_ff | v2_ff | va_ff | vb_ff | vc_ff;

   // pickup sum complete and the result slot free
   assign pick_done = (state_ff == ST_PICKW) && !pk1_v_ff && !pk2_v_ff &&
                      (!rsp_v_ff || rsp_tready);

   // scan pipeline datapath
   always_ff @(posedge clock) begin
      p1_ff <= bef_raddr;
      if (sh1_ff) begin
         tap_ff[0] <= rd_now;
         for (int i = 1; i < dwfs_pkg::TAPS; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
      p2_ff     <= p1_ff;
      bef2_ff   <= rd_bef;
      pa_ff     <= p2_ff;
      nsum_a_ff <= nsum_in;
      ua_ff     <= tap_ff[dwfs_pkg::GRID_Y];
      ba_ff     <= bef2_ff;
      pb_ff     <= pa_ff;
      mc_b_ff   <= coef_c_ff * ua_ff;
      mp_b_ff   <= coef_p_ff * ba_ff;
      mh_b_ff   <= coef_n_ff * $signed(nsum_a_ff[33:16]);
      ml_b_ff   <= coef_n_ff * $signed({1'b0, nsum_a_ff[15:0]});
      pc_ff     <= pb_ff;
      tc_c_ff   <= rc_sum[63:30];
      tp_c_ff   <= rp_sum[63:30];
      tn_c_ff   <= rn_sum[65:30];
      is_c_ff   <= is_in;
      pm_ff     <= $signed({1'b0, pw_sel}) * rd_now;
   end

   // control, setup and pickup
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         bank_ff  <= 1'b0;
         sh1_ff   <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         va_ff    <= 1'b0;
         vb_ff    <= 1'b0;
         vc_ff    <= 1'b0;
         pk1_v_ff <= 1'b0;
         pk2_v_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         sh1_ff   <= (state_ff == ST_SCAN);
         v1_ff    <= (state_ff == ST_SCAN) && (cnt_ff >= AW'(dwfs_pkg::GRID_Y));
         v2_ff    <= v1_ff;
         va_ff    <= v2_ff;
         vb_ff    <= va_ff;
         vc_ff    <= vb_ff;
         pk1_v_ff <= (state_ff == ST_PICK);
         pk1_k_ff <= cnt_ff[1:0];
         pk2_v_ff <= pk1_v_ff;
         if (pk2_v_ff) begin
            pacc_ff <= pacc_ff + 51'(pm_ff);
         end
         if (pick_done) begin
            rsp_v_ff <= 1'b1;
         end else if (rsp_v_ff && rsp_tready) begin
            rsp_v_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               cnt_ff <= cnt_ff + AW'(1);
               if (cnt_ff == AW'(dwfs_pkg::CELLS - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req_tvalid) begin
                  exc_ff   <= req_tdata;
                  state_ff <= ST_PREP;
               end
            end
            ST_PREP: begin
               for (int k = 0; k < 4; k++) begin
                  injp_ff[k] <= w_inj[k] * exc_ff;
               end
               ipos_ff <= {clampx(inj_pos_ff[AW-1:YW], 1, dwfs_pkg::GRID_X - 3),
                           clampy(inj_pos_ff[YW-1:0], 1, dwfs_pkg::GRID_Y - 3)};
               ppos_ff <= {clampx(pick_pos_ff[AW-1:YW], 0, dwfs_pkg::GRID_X - 2),
                           clampy(pick_pos_ff[YW-1:0], 0, dwfs_pkg::GRID_Y - 2)};
               pacc_ff  <= '0;
               state_ff <= ST_PREP2;
            end
            ST_PREP2: begin
               for (int k = 0; k < 4; k++) begin
                  inj_ff[k] <= 17'((injp_ff[k] + 56'sd274877906944) >>> 39);
               end
               cnt_ff   <= '0;
               state_ff <= ST_SCAN;
            end
            ST_SCAN: begin
               cnt_ff <= cnt_ff + AW'(1);
               if (cnt_ff == AW'(dwfs_pkg::CELLS - 1)) state_ff <= ST_DRAIN;
            end
            ST_DRAIN: begin
               if (!pipe_busy) begin
                  bank_ff  <= ~bank_ff;
                  cnt_ff   <= '0;
                  state_ff <= ST_PICK;
               end
            end
            ST_PICK: begin
               cnt_ff <= cnt_ff + AW'(1);
               if (cnt_ff[1:0] == 2'd3) state_ff <= ST_PICKW;
            end
            ST_PICKW: begin
               if (pick_done) begin
                  rsp_d_ff <= dwfs_pkg::sat32(64'($signed(pround[50:15])));
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_d_ff;

   // grid writes only come from the scan pipeline or the clearing pass
   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      wr_pt |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("point write outside scan");

   // the bank swaps only with an empty pipeline
   a_swap_empty: assert property (@(posedge clock) disable iff (reset)
      (bank_ff != $past(bank_ff)) |-> !$past(pipe_busy))
      else $error("bank swap with words in flight");

   // an accepted word starts the setup
   a_accept_prep: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_PREP))
      else $error("accepted word did not start setup");

   // a result appears only at the end of the pickup
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_v_ff) |-> ($past(state_ff) == ST_PICKW))
      else $error("result raised outside pickup");
endmodule
`default_nettype wire

// ----- src/dwfs_ram.sv -----
// single port write, single port read ram with registered read data
`default_nettype none
module dwfs_ram #(
   parameter int DEPTH = dwfs_pkg::CELLS,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [0:DEPTH-1];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire
